/* rtl/motion_cycle_detector_assert.svh */
// Assertion macros shared by the motion cycle detector RTL
`ifndef MOTION_CYCLE_DETECTOR_ASSERT_SVH
`define MOTION_CYCLE_DETECTOR_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define MCD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/mcd_pkg.sv */
// Shared types, constants and register map of the motion cycle detector
package mcd_pkg;

	localparam int SAMPLE_BITS_DEF = 13;
	localparam int GAP_LIMIT_DEF   = 1000;
	localparam int NUM_AXES        = 3;

	localparam int REST_ENERGY_W = 26;
	localparam int MIN_THR_W     = 13;
	localparam int MIN_GAP_W     = 10;
	localparam int TENTHS_W      = 4;
	localparam int CFG_DATA_W    = 26;
	localparam int CFG_IDX_W     = 3;
	localparam int ENERGY_OUT_W  = 26;
	localparam int COUNT_W       = 32;
	localparam int AXIS_W        = 2;

	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
	localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REST_ENERGY = 3'd0,
		REG_THR_FLOOR   = 3'd1,
		REG_MIN_GAP     = 3'd2,
		REG_THR_TENTHS  = 3'd3,
		REG_CYCLE_EN    = 3'd4
	} cfg_reg_t;

	localparam logic [REST_ENERGY_W-1:0] REST_ENERGY_RST = 26'd1600;
	localparam logic [MIN_THR_W-1:0]     MIN_THR_RST     = 13'd50;
	localparam logic [MIN_GAP_W-1:0]     MIN_GAP_RST     = 10'd6;
	localparam logic [TENTHS_W-1:0]      TENTHS_RST      = 4'd4;
	localparam logic                     COUNT_CYC_RST   = 1'b1;

	typedef struct packed {
		logic [REST_ENERGY_W-1:0] rest_energy;
		logic [MIN_THR_W-1:0]     thr_floor;
		logic [MIN_GAP_W-1:0]     min_gap;
		logic [TENTHS_W-1:0]      tenths;
		logic                     cycle_en;
	} mcd_cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOWPASS,
		ST_HIGHPASS,
		ST_SQUARE,
		ST_ENERGY,
		ST_PICK,
		ST_SMOOTH,
		ST_ROOT,
		ST_SCALE,
		ST_DIVIDE,
		ST_DECIDE
	} seq_state_t;

	typedef struct packed {
		logic load;
		logic seed;
		logic upd_lp;
		logic upd_hp;
		logic upd_sq;
		logic upd_en;
	} lane_ctl_t;

	typedef struct packed {
		logic pick;
		logic smooth;
		logic scale;
		logic divide;
		logic decide;
	} merge_ctl_t;

endpackage

/* rtl/mcd_axis_lane.sv */
// One axis lane: low-pass, high-pass, square and energy filter
module mcd_axis_lane import mcd_pkg::*; #(
	parameter int SB = SAMPLE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lane_ctl_t            ctl,
	input  logic signed [SB-1:0] sample,
	output logic signed [SB:0]   hp,
	output logic [2*SB-1:0]      energy
);

	localparam int LPW = SB + 4;
	localparam int HW  = SB + 1;
	localparam int EW  = 2 * SB;

	logic signed [SB-1:0]   x_q;
	logic signed [LPW-1:0]  lp_q;
	logic signed [HW-1:0]   hp_q;
	logic [EW-1:0]          sq_q;
	logic [EW-1:0]          en_q;

	logic signed [LPW-1:0]  x16;
	logic signed [LPW-1:0]  lp_base;
	logic signed [LPW:0]    dlp;
	logic signed [LPW:0]    dlp_adj;
	logic signed [LPW:0]    dlp_sh;
	logic signed [LPW-1:0]  lp_new;
	logic signed [LPW-1:0]  lp_adj;
	logic signed [LPW-1:0]  lp_sh;
	logic signed [SB-1:0]   lp16;
	logic signed [HW-1:0]   hp_new;
	logic signed [2*HW-1:0] sq_full;
	logic signed [EW:0]     den;
	logic signed [EW:0]     den_adj;
	logic signed [EW:0]     den_sh;
	logic [EW-1:0]          en_new;

	// lowpass, seeded with 16x the first sample; /16 truncates toward zero
	assign x16     = {x_q, 4'b0000};
	assign lp_base = ctl.seed ? x16 : lp_q;
	assign dlp     = (LPW+1)'(x16) - (LPW+1)'(lp_base);
	assign dlp_adj = dlp + (LPW+1)'(dlp[LPW] ? 5'sd15 : 5'sd0);
	assign dlp_sh  = dlp_adj >>> 4;
	assign lp_new  = lp_base + LPW'(dlp_sh);

	assign lp_adj  = lp_q + LPW'(lp_q[LPW-1] ? 5'sd15 : 5'sd0);
	assign lp_sh   = lp_adj >>> 4;
	assign lp16    = lp_sh[SB-1:0];
	assign hp_new  = HW'(x_q) - HW'(lp16);

	assign sq_full = hp_q * hp_q;

	// energy stays non-negative and below 2^EW
	assign den     = $signed({1'b0, sq_q}) - $signed({1'b0, en_q});
	assign den_adj = den + (EW+1)'(den[EW] ? 6'sd31 : 6'sd0);
	assign den_sh  = den_adj >>> 5;
	assign en_new  = en_q + den_sh[EW-1:0];

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q <= sample;
		end
		if (ctl.upd_hp) begin
			hp_q <= hp_new;
		end
		if (ctl.upd_sq) begin
			sq_q <= sq_full[EW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q <= '0;
			en_q <= '0;
		end else begin
			if (ctl.upd_lp) begin
				lp_q <= lp_new;
			end
			if (ctl.upd_en) begin
				en_q <= en_new;
			end
		end
	end

	assign hp     = hp_q;
	assign energy = en_q;

endmodule

/* rtl/mcd_isqrt.sv */
// Bit-serial floor square root, one root bit per cycle
module mcd_isqrt import mcd_pkg::*; #(
	parameter int SB = SAMPLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [2*SB-1:0]   value,
	output logic              done,
	output logic [SB-1:0]     root
);

	localparam int EW = 2 * SB;
	localparam int RW = SB + 3;
	localparam int CW = $clog2(SB);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [EW-1:0] val_q;
	logic [RW-1:0] rem_q;
	logic [SB-1:0] root_q;

	logic [RW-1:0] rem_sh;
	logic [RW-1:0] trial;
	logic          take;
	logic          last;

	assign rem_sh = {rem_q[RW-3:0], val_q[EW-1 -: 2]};
	assign trial  = RW'({root_q, 2'b01});
	assign take   = rem_sh >= trial;
	assign last   = cnt_q == CW'(SB - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[EW-3:0], 2'b00};
			rem_q  <= take ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[SB-2:0], take};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* rtl/mcd_merge.sv */
// Merge stage: dominant axis, smoothing, adaptive threshold and trigger
module mcd_merge import mcd_pkg::*; #(
	parameter int SB        = SAMPLE_BITS_DEF,
	parameter int GAP_LIMIT = GAP_LIMIT_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  merge_ctl_t              ctl,
	input  mcd_cfg_t                cfg,
	input  logic signed [SB:0]      hp [NUM_AXES],
	input  logic [2*SB-1:0]         energy [NUM_AXES],
	output logic                    root_done,
	output logic                    cycle_detected,
	output logic [AXIS_W-1:0]       dominant_axis,
	output logic                    is_active,
	output logic [COUNT_W-1:0]      active_samples,
	output logic [ENERGY_OUT_W-1:0] dominant_energy
);

	localparam int HW  = SB + 1;
	localparam int EW  = 2 * SB;
	localparam int PW  = SB + TENTHS_W;
	localparam int QW  = SB + 1;
	localparam int TW  = (QW > MIN_THR_W) ? QW : MIN_THR_W;
	localparam int MEW = (EW > REST_ENERGY_W) ? EW : REST_ENERGY_W;
	localparam int GW  = $clog2(GAP_LIMIT + 1);
	localparam int GCW = (GW > MIN_GAP_W) ? GW : MIN_GAP_W;
	// x/10 as (x * ceil(2^DIV_SH/10)) >> DIV_SH, exact for x < 2^PW
	localparam int DIV_SH = PW + 4;
	localparam int MW     = DIV_SH - 2;
	localparam longint unsigned DIV_MUL_I = ((64'd1 << DIV_SH) + 64'd9) / 64'd10;
	localparam logic [MW-1:0] DIV_MUL = MW'(DIV_MUL_I);

	logic [AXIS_W-1:0]       dom_q;
	logic [EW-1:0]           edom_q;
	logic signed [HW-1:0]    hpdom_q;
	logic signed [HW-1:0]    sm_q;
	logic [GW-1:0]           gap_q;
	logic [COUNT_W-1:0]      act_cnt_q;
	logic                    trig_q;
	logic [PW-1:0]           prod_q;
	logic [QW-1:0]           quo_q;
	logic                    cycle_q;
	logic [AXIS_W-1:0]       dom_out_q;
	logic                    active_q;
	logic [ENERGY_OUT_W-1:0] en_out_q;

	logic [AXIS_W-1:0]       dom01;
	logic [EW-1:0]           e01;
	logic [AXIS_W-1:0]       dom;
	logic signed [HW:0]      dsm;
	logic signed [HW:0]      dsm_adj;
	logic signed [HW:0]      dsm_sh;
	logic signed [HW-1:0]    sm_new;
	logic [SB-1:0]           root;
	logic [PW+MW-1:0]        quo_full;
	logic [TW-1:0]           th;
	logic signed [TW:0]      th_c;
	logic signed [TW:0]      sm_c;
	logic                    resting;
	logic                    below;
	logic                    above;
	logic                    gap_ok;
	logic                    fire;

	mcd_isqrt #(
		.SB (SB)
	) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.smooth),
		.value  (edom_q),
		.done   (root_done),
		.root   (root)
	);

	// strict compares keep the lowest index on ties
	assign dom01 = (energy[1] > energy[0]) ? AXIS_Y : AXIS_X;
	assign e01   = (energy[1] > energy[0]) ? energy[1] : energy[0];
	assign dom   = (energy[2] > e01) ? AXIS_Z : dom01;

	assign dsm     = (HW+1)'(hpdom_q) - (HW+1)'(sm_q);
	assign dsm_adj = dsm + (HW+1)'(dsm[HW] ? 2'sd1 : 2'sd0);
	assign dsm_sh  = dsm_adj >>> 1;
	assign sm_new  = sm_q + HW'(dsm_sh);

	assign quo_full = (PW+MW)'(prod_q) * (PW+MW)'(DIV_MUL);

	assign th      = (TW'(quo_q) > TW'(cfg.thr_floor)) ? TW'(quo_q)
	                                                   : TW'(cfg.thr_floor);
	assign th_c    = $signed({1'b0, th});
	assign sm_c    = (TW+1)'(sm_q);
	assign below   = sm_c < -th_c;
	assign above   = sm_c > th_c;
	assign resting = MEW'(edom_q) < MEW'(cfg.rest_energy);
	assign gap_ok  = GCW'(gap_q) >= GCW'(cfg.min_gap);
	assign fire    = !resting && cfg.cycle_en && trig_q && above && gap_ok;

	always_ff @(posedge clk) begin
		if (ctl.pick) begin
			dom_q   <= dom;
			edom_q  <= energy[dom];
			hpdom_q <= hp[dom];
		end
		if (ctl.scale) begin
			prod_q <= PW'(root) * PW'(cfg.tenths);
		end
		if (ctl.divide) begin
			quo_q <= quo_full[DIV_SH +: QW];
		end
		if (ctl.decide) begin
			cycle_q   <= fire;
			dom_out_q <= dom_q;
			active_q  <= !resting;
			en_out_q  <= ENERGY_OUT_W'(edom_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sm_q      <= '0;
			gap_q     <= '0;
			act_cnt_q <= '0;
			trig_q    <= 1'b0;
		end else begin
			if (ctl.smooth) begin
				sm_q <= sm_new;
				if (gap_q < GW'(GAP_LIMIT)) begin
					gap_q <= gap_q + 1'b1;
				end
			end
			if (ctl.decide) begin
				if (resting) begin
					trig_q <= 1'b0;
				end else begin
					if (act_cnt_q != '1) begin
						act_cnt_q <= act_cnt_q + 1'b1;
					end
					if (cfg.cycle_en) begin
						if (!trig_q && below) begin
							trig_q <= 1'b1;
						end else if (fire) begin
							trig_q <= 1'b0;
							gap_q  <= '0;
						end
					end
				end
			end
		end
	end

	assign cycle_detected  = cycle_q;
	assign dominant_axis   = dom_out_q;
	assign is_active       = active_q;
	assign active_samples  = act_cnt_q;
	assign dominant_energy = en_out_q;

endmodule

/* rtl/motion_cycle_detector.sv */
// Motion cycle detector top level: config registers, sequencer, lanes and merge
//
// channel   direction  handshake              payload
// input     in         in_valid / in_ready    accel_x, accel_y, accel_z
// result    out        out_valid / out_ready  cycle_detected, dominant_axis, is_active,
//                                             active_samples, dominant_energy
// config    in         cfg_en (no wait)       cfg_index, cfg_data
//
// One transaction at a time: a new sample is taken in only once the last one is decided;
// the bit-serial square root, one root bit a cycle, takes most of each transaction.
// A result is registered at its decide step and sits in the output
// register while the next sample is taken in; a stalled output holds the
// sequencer only at the decide step. Reset clears all filter state, no sweep.
`include "motion_cycle_detector_assert.svh"

module motion_cycle_detector import mcd_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int GAP_LIMIT   = GAP_LIMIT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] accel_x,
	input  logic signed [SAMPLE_BITS-1:0] accel_y,
	input  logic signed [SAMPLE_BITS-1:0] accel_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          cycle_detected,
	output logic [AXIS_W-1:0]             dominant_axis,
	output logic                          is_active,
	output logic [COUNT_W-1:0]            active_samples,
	output logic [ENERGY_OUT_W-1:0]       dominant_energy,
	input  logic                          cfg_en,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data
);

	localparam int SB = SAMPLE_BITS;

	seq_state_t state_q;
	seq_state_t state_d;
	mcd_cfg_t   cfg_q;
	logic       seed_q;
	logic       out_valid_q;

	lane_ctl_t  lctl;
	merge_ctl_t mctl;
	logic       slot_free;
	logic       root_done;

	logic signed [SB-1:0] samp   [NUM_AXES];
	logic signed [SB:0]   hp     [NUM_AXES];
	logic [2*SB-1:0]      energy [NUM_AXES];

	assign samp[0] = accel_x;
	assign samp[1] = accel_y;
	assign samp[2] = accel_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rest_energy <= REST_ENERGY_RST;
			cfg_q.thr_floor   <= MIN_THR_RST;
			cfg_q.min_gap     <= MIN_GAP_RST;
			cfg_q.tenths      <= TENTHS_RST;
			cfg_q.cycle_en    <= COUNT_CYC_RST;
		end else if (cfg_en) begin
			unique case (cfg_index)
				REG_REST_ENERGY: cfg_q.rest_energy <= cfg_data[REST_ENERGY_W-1:0];
				REG_THR_FLOOR:   cfg_q.thr_floor   <= cfg_data[MIN_THR_W-1:0];
				REG_MIN_GAP:     cfg_q.min_gap     <= cfg_data[MIN_GAP_W-1:0];
				REG_THR_TENTHS:  cfg_q.tenths      <= cfg_data[TENTHS_W-1:0];
				REG_CYCLE_EN:    cfg_q.cycle_en    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_LOWPASS;
			ST_LOWPASS:  state_d = ST_HIGHPASS;
			ST_HIGHPASS: state_d = ST_SQUARE;
			ST_SQUARE:   state_d = ST_ENERGY;
			ST_ENERGY:   state_d = ST_PICK;
			ST_PICK:     state_d = ST_SMOOTH;
			ST_SMOOTH:   state_d = ST_ROOT;
			ST_ROOT:     if (root_done) state_d = ST_SCALE;
			ST_SCALE:    state_d = ST_DIVIDE;
			ST_DIVIDE:   state_d = ST_DECIDE;
			ST_DECIDE:   if (slot_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = state_q == ST_IDLE;
		lctl.load   = (state_q == ST_IDLE) && in_valid;
		lctl.seed   = seed_q;
		lctl.upd_lp = state_q == ST_LOWPASS;
		lctl.upd_hp = state_q == ST_HIGHPASS;
		lctl.upd_sq = state_q == ST_SQUARE;
		lctl.upd_en = state_q == ST_ENERGY;
		mctl.pick   = state_q == ST_PICK;
		mctl.smooth = state_q == ST_SMOOTH;
		mctl.scale  = state_q == ST_SCALE;
		mctl.divide = state_q == ST_DIVIDE;
		mctl.decide = (state_q == ST_DECIDE) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seed_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (lctl.upd_lp) begin
				seed_q <= 1'b0;
			end
			if (mctl.decide) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
		mcd_axis_lane #(
			.SB (SB)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (lctl),
			.sample (samp[a]),
			.hp     (hp[a]),
			.energy (energy[a])
		);
	end

	mcd_merge #(
		.SB        (SB),
		.GAP_LIMIT (GAP_LIMIT)
	) u_merge (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (mctl),
		.cfg             (cfg_q),
		.hp              (hp),
		.energy          (energy),
		.root_done       (root_done),
		.cycle_detected  (cycle_detected),
		.dominant_axis   (dominant_axis),
		.is_active       (is_active),
		.active_samples  (active_samples),
		.dominant_energy (dominant_energy)
	);

	assign out_valid = out_valid_q;

	`MCD_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second sample taken while busy")
	`MCD_ASSERT_NOW(a_decide_slot, mctl.decide, !out_valid || out_ready, "result overwrote pending output")
	`MCD_ASSERT_NOW(a_cycle_active, out_valid && cycle_detected, is_active, "cycle reported while resting")
	`MCD_ASSERT_NOW(a_axis_code, out_valid, dominant_axis <= AXIS_Z, "dominant axis out of range")
	`MCD_ASSERT_NOW(a_root_in_root, root_done, state_q == ST_ROOT, "square root finished out of step")

endmodule
